FILE: src/sfha_pkg.sv
// Shared types, constants and helpers of the segregated-fit heap allocator.
package sfha_pkg;

    localparam int GRANULE_BYTES = 32;
    localparam int GRAN_SHIFT    = 5;
    localparam int HEADER_BYTES  = 16;
    localparam int SIZE_W        = 11;
    localparam int LINK_W        = 12;
    localparam int LARGE_BYTES   = 32768;
    localparam int BIN_RAW_W     = 4;

    localparam logic [LINK_W-1:0] LINK_NONE = 12'hFFF;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_NULL    = 3'd1,
        ST_OOM     = 3'd2,
        ST_LARGE   = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_bytes;
        logic [15:0] free_address;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] data_address;
    } t_rsp;

    // One boundary-tag record per granule
    typedef struct packed {
        logic              in_use;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] back;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_word;

    typedef enum logic [1:0] {
        FLD_NEXT,
        FLD_PREV,
        FLD_BACK
    } t_fld;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_CHECK, S_UL0, S_UL1, S_RMW_RD, S_RMW_WR,
        S_FILE, S_A_G, S_A_R, S_A_BACK, S_F_RD, S_F_CHK, S_F_WG, S_F_NRD,
        S_F_NCHK, S_F_NMRG, S_F_PRD, S_F_PCHK, S_F_PMRG, S_F_FILE,
        S_FIN_DONE, S_FIN_OOM, S_FIN_INV
    } t_state;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_CLEAR, CMD_ACCEPT, CMD_SCAN, CMD_CHECK, CMD_UL0, CMD_UL1,
        CMD_RMW_RD, CMD_RMW_WR, CMD_FILE, CMD_A_G, CMD_A_R, CMD_A_BACK,
        CMD_F_RD, CMD_F_CHK, CMD_F_WG, CMD_F_NRD, CMD_F_NCHK, CMD_F_NMRG,
        CMD_F_PRD, CMD_F_PCHK, CMD_F_PMRG, CMD_F_FILE, CMD_FINISH
    } t_cmd;

    typedef struct packed {
        t_cmd    op;
        t_status code;
    } t_ctl_s;

    typedef struct packed {
        logic out_busy;
        logic quick;
        logic is_free;
        logic clr_last;
        logic scan_end;
        logic head_none;
        logic fits;
        logic split;
        logic rd_in_use;
        logic prev_none;
        logic next_none;
        logic back_zero;
        logic file_h_none;
    } t_sts_s;

    // Bin before clamping: top set bit of the size in granules, plus one
    function automatic logic [BIN_RAW_W-1:0] bin_raw(input logic [SIZE_W-1:0] size);
        logic [BIN_RAW_W-1:0] b;
        b = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size[i]) begin
                b = BIN_RAW_W'(i + 1);
            end
        end
        return b;
    endfunction

endpackage

FILE: src/sfha_ctrl.sv
// Controller state machine of the heap allocator: sequences datapath commands.
module sfha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  sfha_pkg::t_sts_s i_sts,
    output sfha_pkg::t_ctl_s o_ctl,
    output logic            o_in_take
);

    sfha_pkg::t_state r_state, n_state;
    sfha_pkg::t_state r_ul_ret, n_ul_ret;
    sfha_pkg::t_state r_rmw_ret, n_rmw_ret;
    sfha_pkg::t_state r_fl_ret, n_fl_ret;
    logic             take;

    assign take      = (r_state == sfha_pkg::S_IDLE) && !i_sts.out_busy;
    assign o_in_take = take;

    // Advance state and hold return points
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sfha_pkg::S_CLEAR;
            r_ul_ret  <= sfha_pkg::S_IDLE;
            r_rmw_ret <= sfha_pkg::S_IDLE;
            r_fl_ret  <= sfha_pkg::S_IDLE;
        end else begin
            r_state   <= n_state;
            r_ul_ret  <= n_ul_ret;
            r_rmw_ret <= n_rmw_ret;
            r_fl_ret  <= n_fl_ret;
        end
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        n_ul_ret  = r_ul_ret;
        n_rmw_ret = r_rmw_ret;
        n_fl_ret  = r_fl_ret;
        unique case (r_state)
            sfha_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = sfha_pkg::S_IDLE;
            end
            sfha_pkg::S_IDLE: begin
                if (take && i_in_valid && !i_sts.quick) begin
                    n_state = i_sts.is_free ? sfha_pkg::S_F_RD : sfha_pkg::S_SCAN;
                end
            end
            sfha_pkg::S_SCAN: begin
                if (i_sts.scan_end) n_state = sfha_pkg::S_FIN_OOM;
                else if (!i_sts.head_none) n_state = sfha_pkg::S_CHECK;
            end
            sfha_pkg::S_CHECK: begin
                if (i_sts.fits) begin
                    n_state  = sfha_pkg::S_UL0;
                    n_ul_ret = sfha_pkg::S_A_G;
                end else begin
                    n_state = sfha_pkg::S_SCAN;
                end
            end
            sfha_pkg::S_UL0: begin
                if (i_sts.prev_none) begin
                    n_state = sfha_pkg::S_UL1;
                end else begin
                    n_state   = sfha_pkg::S_RMW_RD;
                    n_rmw_ret = sfha_pkg::S_UL1;
                end
            end
            sfha_pkg::S_UL1: begin
                if (i_sts.next_none) begin
                    n_state = r_ul_ret;
                end else begin
                    n_state   = sfha_pkg::S_RMW_RD;
                    n_rmw_ret = r_ul_ret;
                end
            end
            sfha_pkg::S_RMW_RD: n_state = sfha_pkg::S_RMW_WR;
            sfha_pkg::S_RMW_WR: n_state = r_rmw_ret;
            sfha_pkg::S_FILE: begin
                if (i_sts.file_h_none) begin
                    n_state = r_fl_ret;
                end else begin
                    n_state   = sfha_pkg::S_RMW_RD;
                    n_rmw_ret = r_fl_ret;
                end
            end
            sfha_pkg::S_A_G: begin
                n_state = i_sts.split ? sfha_pkg::S_A_R : sfha_pkg::S_FIN_DONE;
            end
            sfha_pkg::S_A_R: begin
                n_state  = sfha_pkg::S_FILE;
                n_fl_ret = sfha_pkg::S_A_BACK;
            end
            sfha_pkg::S_A_BACK: begin
                n_state   = sfha_pkg::S_RMW_RD;
                n_rmw_ret = sfha_pkg::S_FIN_DONE;
            end
            sfha_pkg::S_F_RD: n_state = sfha_pkg::S_F_CHK;
            sfha_pkg::S_F_CHK: begin
                n_state = i_sts.rd_in_use ? sfha_pkg::S_F_WG : sfha_pkg::S_FIN_INV;
            end
            sfha_pkg::S_F_WG:  n_state = sfha_pkg::S_F_NRD;
            sfha_pkg::S_F_NRD: n_state = sfha_pkg::S_F_NCHK;
            sfha_pkg::S_F_NCHK: begin
                if (i_sts.rd_in_use) begin
                    n_state = sfha_pkg::S_F_PRD;
                end else begin
                    n_state  = sfha_pkg::S_UL0;
                    n_ul_ret = sfha_pkg::S_F_NMRG;
                end
            end
            sfha_pkg::S_F_NMRG: begin
                n_state   = sfha_pkg::S_RMW_RD;
                n_rmw_ret = sfha_pkg::S_F_PRD;
            end
            sfha_pkg::S_F_PRD: begin
                n_state = i_sts.back_zero ? sfha_pkg::S_F_FILE : sfha_pkg::S_F_PCHK;
            end
            sfha_pkg::S_F_PCHK: begin
                if (i_sts.rd_in_use) begin
                    n_state = sfha_pkg::S_F_FILE;
                end else begin
                    n_state  = sfha_pkg::S_UL0;
                    n_ul_ret = sfha_pkg::S_F_PMRG;
                end
            end
            sfha_pkg::S_F_PMRG: begin
                n_state   = sfha_pkg::S_RMW_RD;
                n_rmw_ret = sfha_pkg::S_F_FILE;
            end
            sfha_pkg::S_F_FILE: begin
                n_state  = sfha_pkg::S_FILE;
                n_fl_ret = sfha_pkg::S_FIN_DONE;
            end
            sfha_pkg::S_FIN_DONE, sfha_pkg::S_FIN_OOM, sfha_pkg::S_FIN_INV: begin
                n_state = sfha_pkg::S_IDLE;
            end
            default: n_state = sfha_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_ctl.op   = sfha_pkg::CMD_NOP;
        o_ctl.code = sfha_pkg::ST_DONE;
        unique case (r_state)
            sfha_pkg::S_CLEAR:  o_ctl.op = sfha_pkg::CMD_CLEAR;
            sfha_pkg::S_IDLE: begin
                if (take && i_in_valid) o_ctl.op = sfha_pkg::CMD_ACCEPT;
            end
            sfha_pkg::S_SCAN:   o_ctl.op = sfha_pkg::CMD_SCAN;
            sfha_pkg::S_CHECK:  o_ctl.op = sfha_pkg::CMD_CHECK;
            sfha_pkg::S_UL0:    o_ctl.op = sfha_pkg::CMD_UL0;
            sfha_pkg::S_UL1:    o_ctl.op = sfha_pkg::CMD_UL1;
            sfha_pkg::S_RMW_RD: o_ctl.op = sfha_pkg::CMD_RMW_RD;
            sfha_pkg::S_RMW_WR: o_ctl.op = sfha_pkg::CMD_RMW_WR;
            sfha_pkg::S_FILE:   o_ctl.op = sfha_pkg::CMD_FILE;
            sfha_pkg::S_A_G:    o_ctl.op = sfha_pkg::CMD_A_G;
            sfha_pkg::S_A_R:    o_ctl.op = sfha_pkg::CMD_A_R;
            sfha_pkg::S_A_BACK: o_ctl.op = sfha_pkg::CMD_A_BACK;
            sfha_pkg::S_F_RD:   o_ctl.op = sfha_pkg::CMD_F_RD;
            sfha_pkg::S_F_CHK:  o_ctl.op = sfha_pkg::CMD_F_CHK;
            sfha_pkg::S_F_WG:   o_ctl.op = sfha_pkg::CMD_F_WG;
            sfha_pkg::S_F_NRD:  o_ctl.op = sfha_pkg::CMD_F_NRD;
            sfha_pkg::S_F_NCHK: o_ctl.op = sfha_pkg::CMD_F_NCHK;
            sfha_pkg::S_F_NMRG: o_ctl.op = sfha_pkg::CMD_F_NMRG;
            sfha_pkg::S_F_PRD:  o_ctl.op = sfha_pkg::CMD_F_PRD;
            sfha_pkg::S_F_PCHK: o_ctl.op = sfha_pkg::CMD_F_PCHK;
            sfha_pkg::S_F_PMRG: o_ctl.op = sfha_pkg::CMD_F_PMRG;
            sfha_pkg::S_F_FILE: o_ctl.op = sfha_pkg::CMD_F_FILE;
            sfha_pkg::S_FIN_DONE: begin
                o_ctl.op   = sfha_pkg::CMD_FINISH;
                o_ctl.code = sfha_pkg::ST_DONE;
            end
            sfha_pkg::S_FIN_OOM: begin
                o_ctl.op   = sfha_pkg::CMD_FINISH;
                o_ctl.code = sfha_pkg::ST_OOM;
            end
            sfha_pkg::S_FIN_INV: begin
                o_ctl.op   = sfha_pkg::CMD_FINISH;
                o_ctl.code = sfha_pkg::ST_INVALID;
            end
            default: o_ctl.op = sfha_pkg::CMD_NOP;
        endcase
    end

endmodule

FILE: src/sfha_dp.sv
// Datapath of the heap allocator: tag memory, bin heads, work registers, result item.
module sfha_dp #(
    parameter int ARENA_BYTES = 65536,
    parameter int NUM_BINS    = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfha_pkg::t_ctl_s i_ctl,
    input  sfha_pkg::t_req   i_in,
    input  logic             i_out_stall,
    output sfha_pkg::t_sts_s o_sts,
    output logic             o_out_valid,
    output sfha_pkg::t_rsp   o_out
);

    localparam int GRANULES = ARENA_BYTES / sfha_pkg::GRANULE_BYTES;
    localparam int GW       = $clog2(GRANULES);
    localparam int BW       = $clog2(NUM_BINS);
    localparam int BCW      = $clog2(NUM_BINS + 1);
    localparam int SW       = sfha_pkg::SIZE_W;
    localparam int LW       = sfha_pkg::LINK_W;
    localparam logic [SW-1:0] END_G = SW'(GRANULES - 1);

    // Bin of a size in granules, held at the top bin
    function automatic logic [BW-1:0] bin_of(input logic [SW-1:0] size);
        logic [sfha_pkg::BIN_RAW_W-1:0] raw;
        raw = sfha_pkg::bin_raw(size);
        if (raw > sfha_pkg::BIN_RAW_W'(NUM_BINS - 1)) return BW'(NUM_BINS - 1);
        return BW'(raw);
    endfunction

    sfha_pkg::t_word  r_mem [GRANULES];
    sfha_pkg::t_word  r_rd;
    logic [LW-1:0]    r_heads [NUM_BINS];
    logic             r_op;
    logic [SW-1:0]    r_need;
    logic [BCW-1:0]   r_bin;
    logic [GW-1:0]    r_g;
    sfha_pkg::t_word  r_gw;
    sfha_pkg::t_word  r_uw;
    logic [GW-1:0]    r_fidx;
    sfha_pkg::t_word  r_fw;
    logic [GW-1:0]    r_ra;
    sfha_pkg::t_fld   r_rf;
    logic [LW-1:0]    r_rv;
    logic [GW-1:0]    r_clr;
    logic             r_out_valid;
    sfha_pkg::t_rsp   r_out;

    logic             mem_we, mem_re;
    logic [GW-1:0]    mem_addr;
    sfha_pkg::t_word  mem_wdata;

    logic [16:0]      rounded;
    logic             a_large;
    logic [SW-1:0]    a_need;
    logic             quick;
    sfha_pkg::t_status quick_code;
    logic [SW-1:0]    fa_g;
    logic             scan_end;
    logic [LW-1:0]    scan_head;
    logic             head_none;
    logic [BW-1:0]    u_bin, f_bin;
    logic [LW-1:0]    file_h;
    logic [GW-1:0]    n_idx, p_idx;
    logic [SW-1:0]    nm_size, pm_size;
    sfha_pkg::t_word  clr_word, rmw_word, file_word, ag_word, nm_word, pm_word, chk_word;

    // Decode the request and pick out results that need no memory access
    always_comb begin
        rounded    = (17'(i_in.request_bytes)
                      + 17'(sfha_pkg::HEADER_BYTES + sfha_pkg::GRANULE_BYTES - 1))
                     & ~17'(sfha_pkg::GRANULE_BYTES - 1);
        a_large    = rounded >= 17'(sfha_pkg::LARGE_BYTES);
        a_need     = rounded[sfha_pkg::GRAN_SHIFT +: SW];
        fa_g       = i_in.free_address[15:sfha_pkg::GRAN_SHIFT];
        quick      = 1'b0;
        quick_code = sfha_pkg::ST_NULL;
        if (i_in.operation == sfha_pkg::OP_ALLOC) begin
            if (i_in.request_bytes == '0) begin
                quick = 1'b1;
            end else if (a_large) begin
                quick      = 1'b1;
                quick_code = sfha_pkg::ST_LARGE;
            end
        end else begin
            if (i_in.free_address == '0) begin
                quick = 1'b1;
            end else if (i_in.free_address[sfha_pkg::GRAN_SHIFT-1:0]
                         != sfha_pkg::GRAN_SHIFT'(sfha_pkg::HEADER_BYTES)
                         || fa_g >= END_G) begin
                quick      = 1'b1;
                quick_code = sfha_pkg::ST_INVALID;
            end
        end
    end

    // Derive addresses and records for the current command
    always_comb begin
        scan_end  = r_bin == BCW'(NUM_BINS);
        scan_head = r_heads[r_bin[BW-1:0]];
        head_none = scan_head == sfha_pkg::LINK_NONE;
        u_bin     = bin_of(r_uw.size);
        f_bin     = bin_of(r_fw.size);
        file_h    = r_heads[f_bin];
        n_idx     = r_g + r_gw.size[GW-1:0];
        p_idx     = r_g - r_gw.back[GW-1:0];
        nm_size   = r_gw.size + r_uw.size;
        pm_size   = r_uw.size + r_gw.size;

        clr_word        = '0;
        clr_word.size   = (r_clr == '0) ? END_G : '0;
        clr_word.in_use = r_clr == GW'(GRANULES - 1);
        clr_word.next   = sfha_pkg::LINK_NONE;
        clr_word.prev   = sfha_pkg::LINK_NONE;

        rmw_word = r_rd;
        case (r_rf)
            sfha_pkg::FLD_NEXT: rmw_word.next = r_rv;
            sfha_pkg::FLD_PREV: rmw_word.prev = r_rv;
            default:            rmw_word.back = r_rv[SW-1:0];
        endcase

        file_word      = r_fw;
        file_word.next = file_h;
        file_word.prev = sfha_pkg::LINK_NONE;

        ag_word        = r_gw;
        ag_word.in_use = 1'b1;
        if (r_gw.size > r_need) ag_word.size = r_need;

        nm_word      = r_gw;
        nm_word.size = nm_size;
        pm_word      = r_uw;
        pm_word.size = pm_size;

        chk_word        = r_rd;
        chk_word.in_use = 1'b0;
    end

    // Drive the single memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_g;
        mem_wdata = r_gw;
        case (i_ctl.op)
            sfha_pkg::CMD_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = clr_word;
            end
            sfha_pkg::CMD_SCAN: begin
                mem_re   = !scan_end && !head_none;
                mem_addr = scan_head[GW-1:0];
            end
            sfha_pkg::CMD_RMW_RD: begin
                mem_re   = 1'b1;
                mem_addr = r_ra;
            end
            sfha_pkg::CMD_RMW_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_ra;
                mem_wdata = rmw_word;
            end
            sfha_pkg::CMD_FILE: begin
                mem_we    = 1'b1;
                mem_addr  = r_fidx;
                mem_wdata = file_word;
            end
            sfha_pkg::CMD_A_G: begin
                mem_we    = 1'b1;
                mem_wdata = ag_word;
            end
            sfha_pkg::CMD_F_RD: mem_re = 1'b1;
            sfha_pkg::CMD_F_WG: mem_we = 1'b1;
            sfha_pkg::CMD_F_NRD: begin
                mem_re   = 1'b1;
                mem_addr = n_idx;
            end
            sfha_pkg::CMD_F_NMRG: begin
                mem_we    = 1'b1;
                mem_wdata = nm_word;
            end
            sfha_pkg::CMD_F_PRD: begin
                mem_re   = r_gw.back != '0;
                mem_addr = p_idx;
            end
            sfha_pkg::CMD_F_PMRG: begin
                mem_we    = 1'b1;
                mem_addr  = p_idx;
                mem_wdata = pm_word;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // Tag memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        if (mem_re) r_rd <= r_mem[mem_addr];
    end

    // Control state: clearing counter, bin heads, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++) begin
                r_heads[i] <= (BW'(i) == bin_of(END_G)) ? '0 : sfha_pkg::LINK_NONE;
            end
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (i_ctl.op)
                sfha_pkg::CMD_CLEAR:  r_clr <= r_clr + 1'b1;
                sfha_pkg::CMD_ACCEPT: begin
                    if (quick) r_out_valid <= 1'b1;
                end
                sfha_pkg::CMD_UL0: begin
                    if (r_uw.prev == sfha_pkg::LINK_NONE) r_heads[u_bin] <= r_uw.next;
                end
                sfha_pkg::CMD_FILE:   r_heads[f_bin] <= LW'(r_fidx);
                sfha_pkg::CMD_FINISH: r_out_valid <= 1'b1;
                default: r_clr <= r_clr;
            endcase
        end
    end

    // Work registers and result payload
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            sfha_pkg::CMD_ACCEPT: begin
                r_op   <= i_in.operation;
                r_need <= a_need;
                r_bin  <= BCW'(bin_of(a_need));
                r_g    <= fa_g[GW-1:0];
                if (quick) r_out <= '{status: quick_code, data_address: '0};
            end
            sfha_pkg::CMD_SCAN: begin
                if (!scan_end && head_none) r_bin <= r_bin + 1'b1;
            end
            sfha_pkg::CMD_CHECK: begin
                if (r_rd.size >= r_need) begin
                    r_g  <= scan_head[GW-1:0];
                    r_gw <= r_rd;
                    r_uw <= r_rd;
                end else begin
                    r_bin <= r_bin + 1'b1;
                end
            end
            sfha_pkg::CMD_UL0: begin
                r_ra <= r_uw.prev[GW-1:0];
                r_rf <= sfha_pkg::FLD_NEXT;
                r_rv <= r_uw.next;
            end
            sfha_pkg::CMD_UL1: begin
                r_ra <= r_uw.next[GW-1:0];
                r_rf <= sfha_pkg::FLD_PREV;
                r_rv <= r_uw.prev;
            end
            sfha_pkg::CMD_FILE: begin
                r_ra <= file_h[GW-1:0];
                r_rf <= sfha_pkg::FLD_PREV;
                r_rv <= LW'(r_fidx);
            end
            sfha_pkg::CMD_A_R: begin
                r_fidx <= r_g + r_need[GW-1:0];
                r_fw   <= '{in_use: 1'b0, size: r_gw.size - r_need, back: r_need,
                            next: sfha_pkg::LINK_NONE, prev: sfha_pkg::LINK_NONE};
            end
            sfha_pkg::CMD_A_BACK: begin
                r_ra <= r_fidx + r_fw.size[GW-1:0];
                r_rf <= sfha_pkg::FLD_BACK;
                r_rv <= LW'(r_fw.size);
            end
            sfha_pkg::CMD_F_CHK: r_gw <= chk_word;
            sfha_pkg::CMD_F_NCHK, sfha_pkg::CMD_F_PCHK: r_uw <= r_rd;
            sfha_pkg::CMD_F_NMRG: begin
                r_gw.size <= nm_size;
                r_ra      <= r_g + nm_size[GW-1:0];
                r_rf      <= sfha_pkg::FLD_BACK;
                r_rv      <= LW'(nm_size);
            end
            sfha_pkg::CMD_F_PMRG: begin
                r_g  <= p_idx;
                r_gw <= pm_word;
                r_ra <= p_idx + pm_size[GW-1:0];
                r_rf <= sfha_pkg::FLD_BACK;
                r_rv <= LW'(pm_size);
            end
            sfha_pkg::CMD_F_FILE: begin
                r_fidx <= r_g;
                r_fw   <= r_gw;
            end
            sfha_pkg::CMD_FINISH: begin
                r_out.status <= i_ctl.code;
                if (i_ctl.code == sfha_pkg::ST_DONE && r_op == sfha_pkg::OP_ALLOC) begin
                    r_out.data_address <= 16'({r_g,
                        sfha_pkg::GRAN_SHIFT'(sfha_pkg::HEADER_BYTES)});
                end else begin
                    r_out.data_address <= '0;
                end
            end
            default: r_rv <= r_rv;
        endcase
    end

    // Report status to the controller
    always_comb begin
        o_sts.out_busy    = r_out_valid;
        o_sts.quick       = quick;
        o_sts.is_free     = i_in.operation == sfha_pkg::OP_FREE;
        o_sts.clr_last    = r_clr == GW'(GRANULES - 1);
        o_sts.scan_end    = scan_end;
        o_sts.head_none   = head_none;
        o_sts.fits        = r_rd.size >= r_need;
        o_sts.split       = r_gw.size > r_need;
        o_sts.rd_in_use   = r_rd.in_use;
        o_sts.prev_none   = r_uw.prev == sfha_pkg::LINK_NONE;
        o_sts.next_none   = r_uw.next == sfha_pkg::LINK_NONE;
        o_sts.back_zero   = r_gw.back == '0;
        o_sts.file_h_none = file_h == sfha_pkg::LINK_NONE;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: src/segregated_fit_heap_allocator.sv
// Segregated-fit heap allocator with boundary tags over one arena of ARENA_BYTES in 32-byte
// granules. One item at a time: an item is taken only in idle with no result waiting. The
// result is valid in the cycle after acceptance for null, too large or a bad address. All other
// items are paced by the single-ported tag memory: an allocate steps past each empty bin and
// examines the head of each nonempty bin it reaches (up to NUM_BINS bins), then unlinks, splits,
// files and reports; a free reads the region, reports invalid if it is not in use, else merges
// each free neighbor, files the region and reports. After reset a clearing pass writes every
// record of the tag memory before the first item is taken.
module segregated_fit_heap_allocator #(
    parameter int ARENA_BYTES = 65536,
    parameter int NUM_BINS    = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sfha_pkg::t_req i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sfha_pkg::t_rsp o_out
);

    sfha_pkg::t_ctl_s ctl;
    sfha_pkg::t_sts_s sts;
    logic             in_take;

    sfha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_take  (in_take)
    );

    sfha_dp #(
        .ARENA_BYTES (ARENA_BYTES),
        .NUM_BINS    (NUM_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign o_in_stall = !in_take;

    // Take no item while a result still waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !o_out_valid)
        else $error("item taken while result pending");

    // Answer a trivially decided item in the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && sts.quick) |=> o_out_valid)
        else $error("quick result missing");

    // Return an address only on success
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != sfha_pkg::ST_DONE) |-> (o_out.data_address == '0))
        else $error("address on failed item");

    // Place allocated data one header past a granule start
    a_addr_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.data_address != '0)
        |-> (o_out.data_address[sfha_pkg::GRAN_SHIFT-1:0]
             == sfha_pkg::GRAN_SHIFT'(sfha_pkg::HEADER_BYTES)))
        else $error("misaligned data address");

endmodule
